// ===== design/hnms_pkg.sv =====
// hnms_pkg: shared types for the hard nms box suppressor
// box record layout and controller/datapath command and status groups
// no dependencies
`default_nettype none

package hnms_pkg;

  localparam int unsigned BoxW = 80;
  localparam int unsigned CoordW = 16;
  localparam int unsigned ClassW = 8;
  localparam int unsigned LimitW = 8;
  localparam int unsigned PixOne = 16;

  // left in the lowest bits
  typedef struct packed {
    logic [CoordW-1:0] conf;
    logic [CoordW-1:0] bottom;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] left;
  } box_t;

  typedef struct packed {
    logic load_wr;
    logic drop_set;
    logic class_cap;
    logic rd_box;
    logic box_from_order;
    logic rd_order;
    logic sref_ld;
    logic rank_clr;
    logic rank_step;
    logic order_wr;
    logic keep_set;
    logic x_ld;
    logic supp_set;
    logic out_ld;
    logic clear_load;
  } cmd_t;

  typedef struct packed {
    logic supp_i;
    logic supp_j;
    logic keep_i;
    logic iou_hit;
    logic out_free;
    logic s_gt;
    logic s_eq;
  } status_t;

endpackage

`default_nettype wire

// ===== design/hnms_datapath.sv =====
// hnms_datapath: box and order memories, flags, iou pipeline, output register
// depends on hnms_pkg
`default_nettype none

module hnms_datapath
  import hnms_pkg::*;
#(
  parameter int unsigned MAX_BOXES = 64,
  parameter int unsigned IDX_W = $clog2(MAX_BOXES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  input  wire logic [IDX_W-1:0]  wr_idx_i,
  input  wire logic [IDX_W-1:0]  rd_addr_i,
  input  wire logic [IDX_W-1:0]  i_idx_i,
  input  wire logic [IDX_W-1:0]  j_idx_i,
  input  wire logic              j_lt_i_i,
  input  wire box_t              in_box_i,
  input  wire logic [ClassW-1:0] in_class_i,
  input  wire logic [LimitW-1:0] limit_i,
  output logic [BoxW-1:0]        out_box_o,
  output logic [ClassW-1:0]      out_class_o,
  output logic                   out_final_o,
  output logic                   out_ovf_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i
);

  box_t             box_mem [MAX_BOXES];
  logic [IDX_W-1:0] order_mem [MAX_BOXES];
  box_t             box_rd_q;
  logic [IDX_W-1:0] order_rd_q;
  logic [IDX_W-1:0] box_addr;
  logic [IDX_W-1:0] rank_q;
  logic [CoordW-1:0] sref_q;
  box_t             x_q;
  logic [MAX_BOXES-1:0] supp_q, keep_q, above_mask;
  logic [ClassW-1:0] class_q;
  logic             drop_q;

  assign box_addr = cmd_i.box_from_order ? order_rd_q : rd_addr_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) box_mem[wr_idx_i] <= in_box_i;
    if (cmd_i.rd_box) box_rd_q <= box_mem[box_addr];
    if (cmd_i.order_wr) order_mem[rank_q] <= i_idx_i;
    if (cmd_i.rd_order) order_rd_q <= order_mem[rd_addr_i];
    if (cmd_i.sref_ld) sref_q <= box_rd_q.conf;
    if (cmd_i.x_ld) x_q <= box_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= '0;
      supp_q  <= '0;
      keep_q  <= '0;
      class_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      if (cmd_i.rank_clr) rank_q <= '0;
      else if (cmd_i.rank_step) rank_q <= rank_q + 1'b1;
      if (cmd_i.class_cap) class_q <= in_class_i;
      if (cmd_i.clear_load) begin
        supp_q <= '0;
        keep_q <= '0;
        drop_q <= 1'b0;
      end else begin
        if (cmd_i.drop_set) drop_q <= 1'b1;
        if (cmd_i.keep_set) keep_q[i_idx_i] <= 1'b1;
        if (cmd_i.supp_set) supp_q[j_idx_i] <= 1'b1;
      end
    end
  end

  // iou pipeline, stage 1: spans
  logic signed [17:0] iw_q, ih_q, wx_q, hx_q, wy_q, hy_q;
  logic [CoordW-1:0] il, it, ir, ib;
  always_comb begin
    il = (x_q.left > box_rd_q.left) ? x_q.left : box_rd_q.left;
    it = (x_q.top > box_rd_q.top) ? x_q.top : box_rd_q.top;
    ir = (x_q.right < box_rd_q.right) ? x_q.right : box_rd_q.right;
    ib = (x_q.bottom < box_rd_q.bottom) ? x_q.bottom : box_rd_q.bottom;
  end

  function automatic logic signed [17:0] span(input logic [CoordW-1:0] lo,
                                              input logic [CoordW-1:0] hi);
    span = $signed({2'b00, hi}) - $signed({2'b00, lo}) + 18'sd16;
  endfunction

  always_ff @(posedge clk_i) begin
    iw_q <= span(il, ir);
    ih_q <= span(it, ib);
    wx_q <= span(x_q.left, x_q.right);
    hx_q <= span(x_q.top, x_q.bottom);
    wy_q <= span(box_rd_q.left, box_rd_q.right);
    hy_q <= span(box_rd_q.top, box_rd_q.bottom);
  end

  // stage 2: products
  logic signed [35:0] inner_q, a0_q, a1_q;
  logic               ovl_q, ovl2_q;
  always_ff @(posedge clk_i) begin
    inner_q <= iw_q * ih_q;
    a0_q    <= wx_q * hx_q;
    a1_q    <= wy_q * hy_q;
    ovl_q   <= (iw_q > 18'sd0) && (ih_q > 18'sd0);
  end

  // stage 3: union
  logic signed [37:0] uni_q;
  logic signed [35:0] inner2_q;
  always_ff @(posedge clk_i) begin
    uni_q    <= 38'(a0_q) + 38'(a1_q) - 38'(inner_q);
    inner2_q <= inner_q;
    ovl2_q   <= ovl_q;
  end

  // stage 4: cross-multiplied compare
  logic signed [47:0] lhs, rhs;
  always_comb begin
    lhs = 48'(inner2_q) <<< 8;
    rhs = $signed({1'b0, limit_i}) * 48'(uni_q);
  end

  always_comb begin
    for (int k = 0; k < MAX_BOXES; k++) above_mask[k] = (k > int'(i_idx_i));
  end

  always_comb begin
    status_o.supp_i   = supp_q[i_idx_i];
    status_o.supp_j   = supp_q[j_idx_i];
    status_o.keep_i   = keep_q[i_idx_i];
    status_o.iou_hit  = ovl2_q && (uni_q > 38'sd0) && (lhs > rhs);
    status_o.out_free = !out_valid_o || out_ready_i;
    status_o.s_gt     = box_rd_q.conf > sref_q;
    status_o.s_eq     = (box_rd_q.conf == sref_q) && j_lt_i_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_box_o   <= box_rd_q;
      out_class_o <= class_q;
      out_final_o <= ~|(keep_q & above_mask);
      out_ovf_o   <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.out_ld) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

endmodule

`default_nettype wire

// ===== design/hnms_controller.sv =====
// hnms_controller: sequencer for load, rank sort, greedy walk and emit
// depends on hnms_pkg
`default_nettype none

module hnms_controller
  import hnms_pkg::*;
#(
  parameter int unsigned MAX_BOXES = 64,
  parameter int unsigned IDX_W = $clog2(MAX_BOXES),
  parameter int unsigned CNT_W = $clog2(MAX_BOXES + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_last_i,
  output logic                  in_ready_o,
  input  wire status_t          status_i,
  output cmd_t                  cmd_o,
  output logic [IDX_W-1:0]      wr_idx_o,
  output logic [IDX_W-1:0]      rd_addr_o,
  output logic [IDX_W-1:0]      i_idx_o,
  output logic [IDX_W-1:0]      j_idx_o,
  output logic                  j_lt_i_o
);

  localparam logic [4:0] S_LOAD = 5'd0;
  localparam logic [4:0] S_R_I  = 5'd1;
  localparam logic [4:0] S_R_IW = 5'd2;
  localparam logic [4:0] S_R_J  = 5'd3;
  localparam logic [4:0] S_R_JW = 5'd4;
  localparam logic [4:0] S_R_W  = 5'd5;
  localparam logic [4:0] S_W_I  = 5'd6;
  localparam logic [4:0] S_W_IO = 5'd7;
  localparam logic [4:0] S_W_IB = 5'd8;
  localparam logic [4:0] S_W_J  = 5'd9;
  localparam logic [4:0] S_W_JO = 5'd10;
  localparam logic [4:0] S_W_JB = 5'd11;
  localparam logic [4:0] S_W_P2 = 5'd12;
  localparam logic [4:0] S_W_P3 = 5'd13;
  localparam logic [4:0] S_W_P4 = 5'd14;
  localparam logic [4:0] S_E_I  = 5'd15;
  localparam logic [4:0] S_E_O  = 5'd16;
  localparam logic [4:0] S_E_B  = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_BOXES);

  logic [4:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic             accept;

  assign in_ready_o = (state_q == S_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign wr_idx_o   = cnt_q[IDX_W-1:0];
  assign i_idx_o    = i_q[IDX_W-1:0];
  assign j_idx_o    = j_q[IDX_W-1:0];
  assign j_lt_i_o   = j_q < i_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    cmd_o     = '0;
    rd_addr_o = i_q[IDX_W-1:0];
    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          cmd_o.class_cap = (cnt_q == '0);
          if (cnt_q < CntMax) begin
            cmd_o.load_wr = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            cmd_o.drop_set = 1'b1;
          end
          if (in_last_i) begin
            i_d = '0;
            state_d = S_R_I;
          end
        end
      end
      S_R_I: begin
        cmd_o.rd_box = 1'b1;
        state_d = S_R_IW;
      end
      S_R_IW: begin
        cmd_o.sref_ld  = 1'b1;
        cmd_o.rank_clr = 1'b1;
        j_d = '0;
        state_d = S_R_J;
      end
      S_R_J: begin
        rd_addr_o = j_q[IDX_W-1:0];
        cmd_o.rd_box = 1'b1;
        state_d = S_R_JW;
      end
      S_R_JW: begin
        cmd_o.rank_step = status_i.s_gt || status_i.s_eq;
        j_d = j_q + 1'b1;
        state_d = (j_d == cnt_q) ? S_R_W : S_R_J;
      end
      S_R_W: begin
        cmd_o.order_wr = 1'b1;
        i_d = i_q + 1'b1;
        if (i_d == cnt_q) begin
          i_d = '0;
          state_d = S_W_I;
        end else begin
          state_d = S_R_I;
        end
      end
      S_W_I: begin
        if (i_q == cnt_q) begin
          i_d = '0;
          state_d = S_E_I;
        end else if (status_i.supp_i) begin
          i_d = i_q + 1'b1;
        end else begin
          cmd_o.keep_set = 1'b1;
          cmd_o.rd_order = 1'b1;
          state_d = S_W_IO;
        end
      end
      S_W_IO: begin
        cmd_o.rd_box = 1'b1;
        cmd_o.box_from_order = 1'b1;
        state_d = S_W_IB;
      end
      S_W_IB: begin
        cmd_o.x_ld = 1'b1;
        j_d = i_q + 1'b1;
        state_d = S_W_J;
      end
      S_W_J: begin
        rd_addr_o = j_q[IDX_W-1:0];
        if (j_q == cnt_q) begin
          i_d = i_q + 1'b1;
          state_d = S_W_I;
        end else if (status_i.supp_j) begin
          j_d = j_q + 1'b1;
        end else begin
          cmd_o.rd_order = 1'b1;
          state_d = S_W_JO;
        end
      end
      S_W_JO: begin
        cmd_o.rd_box = 1'b1;
        cmd_o.box_from_order = 1'b1;
        state_d = S_W_JB;
      end
      S_W_JB: state_d = S_W_P2;
      S_W_P2: state_d = S_W_P3;
      S_W_P3: state_d = S_W_P4;
      S_W_P4: begin
        cmd_o.supp_set = status_i.iou_hit;
        j_d = j_q + 1'b1;
        state_d = S_W_J;
      end
      S_E_I: begin
        if (i_q == cnt_q) begin
          state_d = S_DONE;
        end else if (!status_i.keep_i) begin
          i_d = i_q + 1'b1;
        end else begin
          cmd_o.rd_order = 1'b1;
          state_d = S_E_O;
        end
      end
      S_E_O: begin
        cmd_o.rd_box = 1'b1;
        cmd_o.box_from_order = 1'b1;
        state_d = S_E_B;
      end
      S_E_B: begin
        if (status_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          i_d = i_q + 1'b1;
          state_d = S_E_I;
        end
      end
      S_DONE: begin
        cmd_o.clear_load = 1'b1;
        cnt_d = '0;
        state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/hard_nms_box_suppressor.sv =====
// hard_nms_box_suppressor: greedy hard non-maximum suppression, one class per load
// top level; instantiates hnms_controller and hnms_datapath, uses hnms_pkg
//
// usage: stream one class's proposals on the s_axis channel, tlast on the final one.
// the class is taken from tuser of the first transaction. boxes past MAX_BOXES are
// dropped and every result of that load carries capacity_overflow.
// after the last transaction the block ranks the boxes by score, then walks them
// greedily with a four-stage iou pipeline, testing up to n*(n-1)/2 pairs one at a
// time, then emits the kept boxes in score order, tlast on the last one. the run time
// of a load is set by the single read port of the box memory. s_axis_tready_o is high
// only while a load is being taken in.
// the result sits in an output register; when m_axis_tready_i is low the emit step
// waits, nothing is lost. a new load may start while the final result still waits.
// reset clears the control state and sets iou_limit_q8 to 128; box memories need no
// clearing. cfg is to be written only while idle; the block does not enforce it. cfg_ready_o is always high.
`default_nettype none

module hard_nms_box_suppressor
  import hnms_pkg::*;
#(
  parameter int unsigned MAX_BOXES = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [79:0]  s_axis_tdata_i,   // box_left, box_top, box_right, box_bottom, box_confidence
  input  wire logic [7:0]   s_axis_tuser_i,   // class_label
  input  wire logic         s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [79:0]       m_axis_tdata_o,   // kept_left, kept_top, kept_right, kept_bottom, kept_confidence
  output logic [8:0]        m_axis_tuser_o,   // kept_class, capacity_overflow
  output logic              m_axis_tlast_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [7:0]   cfg_data_i        // iou_limit_q8
);

  localparam int unsigned IdxW = $clog2(MAX_BOXES);
  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);

  cmd_t              cmd;
  status_t           status;
  logic [IdxW-1:0]   wr_idx, rd_addr, i_idx, j_idx;
  logic              j_lt_i;
  logic [LimitW-1:0] limit_q;
  logic [ClassW-1:0] out_class;
  logic              out_ovf;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= LimitW'(128);
    else if (cfg_valid_i) limit_q <= cfg_data_i;
  end

  hnms_controller #(
    .MAX_BOXES(MAX_BOXES),
    .IDX_W    (IdxW),
    .CNT_W    (CntW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_last_i (s_axis_tlast_i),
    .in_ready_o(s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd),
    .wr_idx_o  (wr_idx),
    .rd_addr_o (rd_addr),
    .i_idx_o   (i_idx),
    .j_idx_o   (j_idx),
    .j_lt_i_o  (j_lt_i)
  );

  hnms_datapath #(
    .MAX_BOXES(MAX_BOXES),
    .IDX_W    (IdxW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .wr_idx_i   (wr_idx),
    .rd_addr_i  (rd_addr),
    .i_idx_i    (i_idx),
    .j_idx_i    (j_idx),
    .j_lt_i_i   (j_lt_i),
    .in_box_i   (s_axis_tdata_i),
    .in_class_i (s_axis_tuser_i),
    .limit_i    (limit_q),
    .out_box_o  (m_axis_tdata_o),
    .out_class_o(out_class),
    .out_final_o(m_axis_tlast_o),
    .out_ovf_o  (out_ovf),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i)
  );

  assign m_axis_tuser_o = {out_ovf, out_class};

endmodule

`default_nettype wire

// ===== test/hard_nms_box_suppressor_chk.sv =====
// hard_nms_box_suppressor_chk: watches the box, result and config channels of the suppressor
// predicts the kept boxes of each load and compares them; depends on hnms_pkg
`timescale 1ns / 100ps

module hard_nms_box_suppressor_chk
  import hnms_pkg::*;
#(
  parameter int unsigned MAX_BOXES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [79:0] s_axis_tdata_i,
  input  wire logic [7:0]  s_axis_tuser_i,
  input  wire logic        s_axis_tlast_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [79:0] m_axis_tdata_i,
  input  wire logic [8:0]  m_axis_tuser_i,
  input  wire logic        m_axis_tlast_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [7:0]  cfg_data_i,
  output int               fail_cnt_o,
  output int               pending_o
);

  typedef struct {
    box_t       box;
    logic [7:0] cls;
    logic       fin;
    logic       ovf;
  } kept_box_t;

  kept_box_t  kept_q[$];
  box_t       load_boxes[MAX_BOXES];
  int         load_cnt;
  logic       load_drop;
  logic [7:0] load_cls;
  logic [7:0] iou_limit;

  assign pending_o = kept_q.size();

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  // true when kept box x knocks out candidate y; areas are signed so malformed boxes work
  function automatic bit overlaps_too_much(box_t x, box_t y, logic [7:0] lim);
    longint iw, ih, inner, a0, a1, uni;
    iw = lmin(x.right, y.right) - lmax(x.left, y.left) + PixOne;
    ih = lmin(x.bottom, y.bottom) - lmax(x.top, y.top) + PixOne;
    if (iw <= 0 || ih <= 0) return 0;
    inner = iw * ih;
    a0 = (longint'(x.right) - longint'(x.left) + PixOne) *
         (longint'(x.bottom) - longint'(x.top) + PixOne);
    a1 = (longint'(y.right) - longint'(y.left) + PixOne) *
         (longint'(y.bottom) - longint'(y.top) + PixOne);
    uni = a0 + a1 - inner;
    if (uni <= 0) return 0;
    return inner * 256 > longint'(lim) * uni;
  endfunction

  // stable sort by descending score, then greedy walk
  function automatic void suppress_load();
    int  order[$];
    bit  gone[MAX_BOXES];
    int  kept[$];
    int  j;
    kept_box_t k;
    for (int i = 0; i < load_cnt; i++) begin
      j = 0;
      while (j < order.size() && load_boxes[order[j]].conf >= load_boxes[i].conf) j++;
      order.insert(j, i);
    end
    for (int i = 0; i < load_cnt; i++) gone[i] = 0;
    for (int i = 0; i < load_cnt; i++) begin
      if (!gone[i]) begin
        kept.insert(kept.size(), order[i]);
        for (int m = i + 1; m < load_cnt; m++)
          if (!gone[m] && overlaps_too_much(load_boxes[order[i]], load_boxes[order[m]], iou_limit))
            gone[m] = 1;
      end
    end
    foreach (kept[n]) begin
      k.box = load_boxes[kept[n]];
      k.cls = load_cls;
      k.fin = (n == kept.size() - 1);
      k.ovf = load_drop;
      kept_q.insert(kept_q.size(), k);
    end
  endfunction

  function automatic void cmp_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_cnt_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    box_t      got;
    kept_box_t exp_k;
    if (!rst_ni) begin
      load_cnt   = 0;
      load_drop  = 0;
      load_cls   = '0;
      iou_limit  = 8'd128;
      fail_cnt_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) iou_limit = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (load_cnt == 0 && !load_drop) load_cls = s_axis_tuser_i;
        if (load_cnt < MAX_BOXES) begin
          load_boxes[load_cnt] = s_axis_tdata_i;
          load_cnt++;
        end else begin
          load_drop = 1;
        end
        if (s_axis_tlast_i) begin
          suppress_load();
          load_cnt  = 0;
          load_drop = 0;
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none actual %0h", $time,
                   m_axis_tdata_i);
          fail_cnt_o++;
        end else begin
          exp_k = kept_q.pop_front();
          got   = m_axis_tdata_i;
          cmp_field("kept_left", exp_k.box.left, got.left);
          cmp_field("kept_top", exp_k.box.top, got.top);
          cmp_field("kept_right", exp_k.box.right, got.right);
          cmp_field("kept_bottom", exp_k.box.bottom, got.bottom);
          cmp_field("kept_confidence", exp_k.box.conf, got.conf);
          cmp_field("kept_class", exp_k.cls, m_axis_tuser_i[7:0]);
          cmp_field("capacity_overflow", exp_k.ovf, m_axis_tuser_i[8]);
          cmp_field("final_result", exp_k.fin, m_axis_tlast_i);
        end
      end
    end
  end

endmodule

// ===== test/hard_nms_box_suppressor_tb.sv =====
// hard_nms_box_suppressor_tb: stimulus and verdict for the box suppressor
// drives loads of proposals and threshold writes; checking in hard_nms_box_suppressor_chk
`timescale 1ns / 100ps

module hard_nms_box_suppressor_tb;
  import hnms_pkg::*;

  localparam int unsigned MaxBoxes = 64;
  localparam int StallLimit = 200000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [7:0]  s_tuser = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;
  logic [8:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  int          fail_cnt;
  int          pending;
  int          quiet_cycles = 0;
  int          boxes_sent = 0;
  bit          no_gaps = 0;
  int          stall_mode = 0;

  always #2 clk_i = ~clk_i;

  hard_nms_box_suppressor #(.MAX_BOXES(MaxBoxes)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .s_axis_tuser_i(s_tuser), .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  hard_nms_box_suppressor_chk #(.MAX_BOXES(MaxBoxes)) u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready), .s_axis_tdata_i(s_tdata),
    .s_axis_tuser_i(s_tuser), .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_i(m_tdata),
    .m_axis_tuser_i(m_tuser), .m_axis_tlast_i(m_tlast),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side backpressure, mode changes now and then
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 19) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic push_box(input box_t b, input logic [7:0] cls, input logic last);
    repeat (gap_len()) @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tuser  = cls;
    s_tlast  = last;
    while (!s_tready) @(negedge clk_i);
    @(negedge clk_i);
    s_tvalid = 1'b0;
    boxes_sent++;
  endtask

  task automatic write_limit(input logic [7:0] lim);
    wait (pending == 0);
    repeat (30) @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data  = lim;
    while (!cfg_ready) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic box_t mk_box(int l, int t, int w, int h, int s);
    box_t b;
    b.left = 16'(l); b.top = 16'(t); b.right = 16'(l + w); b.bottom = 16'(t + h);
    b.conf = 16'(s);
    return b;
  endfunction

  // boxes scattered around one center per load so that overlaps happen
  function automatic box_t rand_box(int cx, int cy);
    if ($urandom_range(0, 5) == 0) return box_t'(80'({$urandom, $urandom, $urandom}));
    return mk_box(cx + $urandom_range(0, 300), cy + $urandom_range(0, 300),
                  $urandom_range(0, 600), $urandom_range(0, 600),
                  ($urandom_range(0, 3) == 0) ? 16'h8000 : $urandom_range(0, 65535));
  endfunction

  task automatic rand_load(input int n);
    logic [7:0] cls;
    int cx, cy;
    cls = 8'($urandom);
    cx = $urandom_range(0, 64000);
    cy = $urandom_range(0, 64000);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++)
      push_box(rand_box(cx, cy), ($urandom_range(0, 1) ? cls : 8'($urandom)), i == n - 1);
    no_gaps = 0;
  endtask

  initial begin
    int n;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // default limit: identical boxes, tie in score, disjoint box, extremes
    push_box(mk_box(100, 100, 160, 160, 5000), 8'hff, 0);
    push_box(mk_box(100, 100, 160, 160, 5000), 8'h00, 0);
    push_box(mk_box(1000, 1000, 16, 16, 65535), 8'h11, 0);
    push_box(mk_box(0, 0, 0, 0, 0), 8'h22, 1);
    // single-box load with all fields at the top
    push_box(box_t'({5{16'hffff}}), 8'hff, 1);
    // malformed boxes: negative widths and heights, inverted corners
    push_box(box_t'({16'd900, 16'd0, 16'd0, 16'hffff, 16'hffff}), 8'h5a, 0);
    push_box(box_t'({16'd800, 16'd40, 16'd40, 16'd200, 16'd200}), 8'h5a, 0);
    push_box(mk_box(10, 10, 200, 200, 700), 8'h5a, 1);
    write_limit(8'd0);
    // limit zero: any touching overlap suppresses, adjacent corners just touch
    push_box(mk_box(0, 0, 64, 64, 300), 8'h01, 0);
    push_box(mk_box(64, 64, 64, 64, 200), 8'h01, 0);
    push_box(mk_box(81, 81, 64, 64, 100), 8'h01, 1);
    write_limit(8'd255);
    // limit at the top: only near-identical boxes suppress
    push_box(mk_box(500, 500, 320, 320, 4), 8'h80, 0);
    push_box(mk_box(500, 500, 320, 320, 9), 8'h80, 0);
    push_box(mk_box(501, 500, 320, 320, 9), 8'h80, 1);
    write_limit(8'd128);

    // random phases with different limits; one load just past capacity
    while (boxes_sent < 45) begin
      if ($urandom_range(0, 2) == 0) write_limit(8'($urandom_range(0, 255)));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      rand_load(n);
    end
    write_limit(8'd77);
    rand_load(MaxBoxes + 1);
    write_limit(8'd200);
    rand_load(3);

    wait (pending == 0);
    repeat (200) @(negedge clk_i);
    if (fail_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
